>>> hdl/closest_hit_triangle_batch_assert.svh
// ----------------------------------------------------------------------------
// closest_hit_triangle_batch_assert.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_HIT_TRIANGLE_BATCH_ASSERT_SVH
`define CLOSEST_HIT_TRIANGLE_BATCH_ASSERT_SVH

// same-cycle implication, held off during reset
`define CHTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CHTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also checks across reset
`define CHTB_ASSERT_NEXT_NR(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/chtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtb_pkg
// Types, constants and the multiply schedule of the closest-hit intersector.
// ----------------------------------------------------------------------------
package chtb_pkg;

    localparam int EW     = 33;   // vertex difference width
    localparam int NW     = 19;   // negated direction width
    localparam int BW     = 68;   // cross product width
    localparam int AW     = 104;  // determinant accumulator width
    localparam int DW     = 136;  // divider width
    localparam int DIST_W = 31;
    localparam int IDX_W  = 10;
    localparam int NUM_OPS = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int IN_W  = 288;
    localparam int OUT_W = 48;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [17:0] DIR_Z_RESET = 18'd65536;
    localparam logic [39:0] EPS_RESET   = 40'd28147498;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DET_EPS  = 3'd6;

    // operand selects
    localparam logic [4:0] SEL_E1X = 5'd0;
    localparam logic [4:0] SEL_E1Y = 5'd1;
    localparam logic [4:0] SEL_E1Z = 5'd2;
    localparam logic [4:0] SEL_E2X = 5'd3;
    localparam logic [4:0] SEL_E2Y = 5'd4;
    localparam logic [4:0] SEL_E2Z = 5'd5;
    localparam logic [4:0] SEL_SX  = 5'd6;
    localparam logic [4:0] SEL_SY  = 5'd7;
    localparam logic [4:0] SEL_SZ  = 5'd8;
    localparam logic [4:0] SEL_NDX = 5'd9;
    localparam logic [4:0] SEL_NDY = 5'd10;
    localparam logic [4:0] SEL_NDZ = 5'd11;
    localparam logic [4:0] SEL_U0  = 5'd12;
    localparam logic [4:0] SEL_U1  = 5'd13;
    localparam logic [4:0] SEL_U2  = 5'd14;
    localparam logic [4:0] SEL_V0  = 5'd15;
    localparam logic [4:0] SEL_V1  = 5'd16;
    localparam logic [4:0] SEL_V2  = 5'd17;
    localparam logic [4:0] SEL_W0  = 5'd18;
    localparam logic [4:0] SEL_W1  = 5'd19;
    localparam logic [4:0] SEL_W2  = 5'd20;

    // accumulate destinations
    localparam logic [3:0] DST_U0  = 4'd0;
    localparam logic [3:0] DST_U1  = 4'd1;
    localparam logic [3:0] DST_U2  = 4'd2;
    localparam logic [3:0] DST_V0  = 4'd3;
    localparam logic [3:0] DST_V1  = 4'd4;
    localparam logic [3:0] DST_V2  = 4'd5;
    localparam logic [3:0] DST_W0  = 4'd6;
    localparam logic [3:0] DST_W1  = 4'd7;
    localparam logic [3:0] DST_W2  = 4'd8;
    localparam logic [3:0] DST_DET = 4'd9;
    localparam logic [3:0] DST_NA  = 4'd10;
    localparam logic [3:0] DST_NB  = 4'd11;
    localparam logic [3:0] DST_NT  = 4'd12;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic       done;
        logic [3:0] dest;
    } t_uop;

    typedef struct packed {
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] e2;
        logic [2:0][EW-1:0] s;
        logic [IDX_W-1:0]   index;
        logic               counted;
        logic               last;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DRAIN, ST_CHK1, ST_CHK2, ST_DIV, ST_UPD
    } t_state;

    // cross products u = e2 x nd, v = nd x e1, w = e1 x e2, then
    // det = e1.u, na = s.u, nb = s.v, nt = s.w
    function automatic t_uop uop_rom(input logic [4:0] idx);
        t_uop u;
        case (idx)
            5'd0:  u = '{SEL_E2Y, SEL_NDZ, 1'b0, 1'b0, DST_U0};
            5'd1:  u = '{SEL_E2Z, SEL_NDY, 1'b1, 1'b1, DST_U0};
            5'd2:  u = '{SEL_E2Z, SEL_NDX, 1'b0, 1'b0, DST_U1};
            5'd3:  u = '{SEL_E2X, SEL_NDZ, 1'b1, 1'b1, DST_U1};
            5'd4:  u = '{SEL_E2X, SEL_NDY, 1'b0, 1'b0, DST_U2};
            5'd5:  u = '{SEL_E2Y, SEL_NDX, 1'b1, 1'b1, DST_U2};
            5'd6:  u = '{SEL_E1Z, SEL_NDY, 1'b0, 1'b0, DST_V0};
            5'd7:  u = '{SEL_E1Y, SEL_NDZ, 1'b1, 1'b1, DST_V0};
            5'd8:  u = '{SEL_E1X, SEL_NDZ, 1'b0, 1'b0, DST_V1};
            5'd9:  u = '{SEL_E1Z, SEL_NDX, 1'b1, 1'b1, DST_V1};
            5'd10: u = '{SEL_E1Y, SEL_NDX, 1'b0, 1'b0, DST_V2};
            5'd11: u = '{SEL_E1X, SEL_NDY, 1'b1, 1'b1, DST_V2};
            5'd12: u = '{SEL_E1Y, SEL_E2Z, 1'b0, 1'b0, DST_W0};
            5'd13: u = '{SEL_E1Z, SEL_E2Y, 1'b1, 1'b1, DST_W0};
            5'd14: u = '{SEL_E1Z, SEL_E2X, 1'b0, 1'b0, DST_W1};
            5'd15: u = '{SEL_E1X, SEL_E2Z, 1'b1, 1'b1, DST_W1};
            5'd16: u = '{SEL_E1X, SEL_E2Y, 1'b0, 1'b0, DST_W2};
            5'd17: u = '{SEL_E1Y, SEL_E2X, 1'b1, 1'b1, DST_W2};
            5'd18: u = '{SEL_E1X, SEL_U0, 1'b0, 1'b0, DST_DET};
            5'd19: u = '{SEL_E1Y, SEL_U1, 1'b0, 1'b0, DST_DET};
            5'd20: u = '{SEL_E1Z, SEL_U2, 1'b0, 1'b1, DST_DET};
            5'd21: u = '{SEL_SX,  SEL_U0, 1'b0, 1'b0, DST_NA};
            5'd22: u = '{SEL_SY,  SEL_U1, 1'b0, 1'b0, DST_NA};
            5'd23: u = '{SEL_SZ,  SEL_U2, 1'b0, 1'b1, DST_NA};
            5'd24: u = '{SEL_SX,  SEL_V0, 1'b0, 1'b0, DST_NB};
            5'd25: u = '{SEL_SY,  SEL_V1, 1'b0, 1'b0, DST_NB};
            5'd26: u = '{SEL_SZ,  SEL_V2, 1'b0, 1'b1, DST_NB};
            5'd27: u = '{SEL_SX,  SEL_W0, 1'b0, 1'b0, DST_NT};
            5'd28: u = '{SEL_SY,  SEL_W1, 1'b0, 1'b0, DST_NT};
            5'd29: u = '{SEL_SZ,  SEL_W2, 1'b0, 1'b1, DST_NT};
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

>>> hdl/closest_hit_triangle_batch.sv
`timescale 1ns / 1ps
// Datapath: 30 steps on the shared 33x35 multiplier, each a low and a high half, then
// a one-bit-per-cycle divider for t; triangles past the batch limit skip both. The
// engine works on one triangle at a time; a two-word queue absorbs input bursts.
// Reset: synchronous, active low; control and configuration registers take their defaults, queue empties.
// ----------------------------------------------------------------------------
// closest_hit_triangle_batch
// Streams a batch of triangles against one configured ray, returns the
// closest hit of the batch on the word marked last.
// ----------------------------------------------------------------------------
module closest_hit_triangle_batch #(
    parameter int MAX_TRIANGLES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [chtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [chtb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z (32 bits each)
    input  logic [chtb_pkg::IN_W-1:0]       i_s_tdata,
    input  logic                            i_s_tlast,   // batch_end
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // hit_index [9:0], hit_distance [40:10], zero fill
    output logic [chtb_pkg::OUT_W-1:0]      o_m_tdata,
    output logic                            o_m_tuser    // hit
);

    logic [2:0][31:0]            r_origin;
    logic [2:0][17:0]            r_dir;
    logic [39:0]                 r_eps;
    logic [2:0][chtb_pkg::NW-1:0] nd;

    logic             push, full, q_valid, pop;
    chtb_pkg::t_entry f_entry, q_entry;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_dir    <= {chtb_pkg::DIR_Z_RESET, 18'd0, 18'd0};
            r_eps    <= chtb_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                chtb_pkg::REG_ORIGIN_X: r_origin[0] <= i_cfg_wdata[31:0];
                chtb_pkg::REG_ORIGIN_Y: r_origin[1] <= i_cfg_wdata[31:0];
                chtb_pkg::REG_ORIGIN_Z: r_origin[2] <= i_cfg_wdata[31:0];
                chtb_pkg::REG_DIR_X:    r_dir[0]    <= i_cfg_wdata[17:0];
                chtb_pkg::REG_DIR_Y:    r_dir[1]    <= i_cfg_wdata[17:0];
                chtb_pkg::REG_DIR_Z:    r_dir[2]    <= i_cfg_wdata[17:0];
                chtb_pkg::REG_DET_EPS:  r_eps       <= i_cfg_wdata[39:0];
                default: ;
            endcase
        end
    end

    // third matrix column is the negated direction
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nd[k] = -$signed({r_dir[k][17], r_dir[k]});
        end
    end

    chtb_front #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_origin   (r_origin),
        .o_push     (push),
        .o_entry    (f_entry),
        .i_full     (full)
    );

    chtb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    chtb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (q_entry),
        .o_pop      (pop),
        .i_nd       (nd),
        .i_eps      (r_eps),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> hdl/chtb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtb_front
// Accepts triangle words, forms edge and origin offsets, numbers the batch.
// ----------------------------------------------------------------------------
module chtb_front #(
    parameter int MAX_TRIANGLES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [chtb_pkg::IN_W-1:0] i_s_tdata,
    input  logic                      i_s_tlast,
    input  logic [2:0][31:0]          i_origin,
    output logic                      o_push,
    output chtb_pkg::t_entry          o_entry,
    input  logic                      i_full
);

    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             accept;
    logic             counted;

    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign counted    = r_count < CNT_W'(MAX_TRIANGLES);
    assign o_push     = accept;

    // offsets B-A, C-A and O-A per axis
    always_comb begin
        logic [31:0] a, b, c;
        for (int k = 0; k < 3; k++) begin
            a = i_s_tdata[32*k +: 32];
            b = i_s_tdata[96 + 32*k +: 32];
            c = i_s_tdata[192 + 32*k +: 32];
            o_entry.e1[k] = $signed({b[31], b}) - $signed({a[31], a});
            o_entry.e2[k] = $signed({c[31], c}) - $signed({a[31], a});
            o_entry.s[k]  = $signed({i_origin[k][31], i_origin[k]}) - $signed({a[31], a});
        end
        o_entry.index   = chtb_pkg::IDX_W'(r_count);
        o_entry.counted = counted;
        o_entry.last    = i_s_tlast;
    end

    // batch position, saturating at the limit
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_s_tlast) begin
                n_count = '0;
            end else if (counted) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/chtb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtb_fifo
// Two-entry queue between the front and the intersect engine.
// ----------------------------------------------------------------------------
module chtb_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  chtb_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    output chtb_pkg::t_entry o_entry,
    input  logic             i_pop
);

    chtb_pkg::t_entry r_mem [0:1];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, n_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_entry = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hdl/chtb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtb_back
// Determinants on one shared multiplier, barycentric tests, serial divide,
// running minimum and the result word register.
// ----------------------------------------------------------------------------
module chtb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  chtb_pkg::t_entry            i_entry,
    output logic                        o_pop,
    input  logic [2:0][chtb_pkg::NW-1:0] i_nd,
    input  logic [39:0]                 i_eps,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [chtb_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                        o_m_tuser
);

    localparam int AW = chtb_pkg::AW;
    localparam int BW = chtb_pkg::BW;
    localparam int DW = chtb_pkg::DW;
    localparam int EW = chtb_pkg::EW;

    chtb_pkg::t_state r_state, n_state;
    chtb_pkg::t_entry r_ent;

    // multiply sequencer
    logic [4:0]            r_op;
    logic                  r_phase;
    chtb_pkg::t_uop        op;
    logic signed [EW-1:0]  a_val;
    logic signed [BW-1:0]  b_val;
    logic signed [34:0]    m_b;
    logic signed [67:0]    prod;
    logic                  last_step;

    // product stage
    logic signed [67:0]    r_prod;
    logic                  r_p_vld, r_p_hi, r_p_neg, r_p_done;
    logic [3:0]            r_p_dest;

    // accumulate stage
    logic signed [AW-1:0]  r_acc, term, acc_sum;
    logic signed [BW-1:0]  r_uvw [0:8];
    logic signed [AW-1:0]  r_det, r_na, r_nb, r_nt;

    // checks and divide
    logic [AW-1:0]         r_d;
    logic signed [AW-1:0]  r_fa, r_fb, r_ft, dma, dmab;
    logic                  r_zero, reject, sat;
    logic [DW-1:0]         x_val, d_lim, r_rem, r_dsh;
    logic [4:0]            r_bit;
    logic [chtb_pkg::DIST_W-1:0] r_q, r_t;
    logic                  ge;

    // running minimum and output word
    logic                  r_found;
    logic [chtb_pkg::DIST_W-1:0] r_best;
    logic [chtb_pkg::IDX_W-1:0]  r_bidx;
    logic                  cand, out_free, out_load, upd_acc;
    logic                  r_out_vld, r_out_hit;
    logic [chtb_pkg::IDX_W-1:0]  r_out_idx;
    logic [chtb_pkg::DIST_W-1:0] r_out_dist;

    function automatic logic signed [EW-1:0] pick(
        input chtb_pkg::t_entry e,
        input logic [2:0][chtb_pkg::NW-1:0] nd,
        input logic [4:0] sel
    );
        logic signed [EW-1:0] v;
        case (sel)
            chtb_pkg::SEL_E1X: v = $signed(e.e1[0]);
            chtb_pkg::SEL_E1Y: v = $signed(e.e1[1]);
            chtb_pkg::SEL_E1Z: v = $signed(e.e1[2]);
            chtb_pkg::SEL_E2X: v = $signed(e.e2[0]);
            chtb_pkg::SEL_E2Y: v = $signed(e.e2[1]);
            chtb_pkg::SEL_E2Z: v = $signed(e.e2[2]);
            chtb_pkg::SEL_SX:  v = $signed(e.s[0]);
            chtb_pkg::SEL_SY:  v = $signed(e.s[1]);
            chtb_pkg::SEL_SZ:  v = $signed(e.s[2]);
            chtb_pkg::SEL_NDX: v = EW'($signed(nd[0]));
            chtb_pkg::SEL_NDY: v = EW'($signed(nd[1]));
            chtb_pkg::SEL_NDZ: v = EW'($signed(nd[2]));
            default:           v = '0;
        endcase
        return v;
    endfunction

    // operand selection and one 33 x 35 partial product
    always_comb begin
        op    = chtb_pkg::uop_rom(r_op);
        a_val = pick(r_ent, i_nd, op.a_sel);
        if (op.b_sel >= chtb_pkg::SEL_U0) begin
            b_val = r_uvw[4'(op.b_sel - chtb_pkg::SEL_U0)];
        end else begin
            b_val = BW'(pick(r_ent, i_nd, op.b_sel));
        end
        m_b  = r_phase ? 35'($signed(b_val[BW-1:34])) : $signed({1'b0, b_val[33:0]});
        prod = a_val * m_b;
        last_step = (r_op == 5'(chtb_pkg::NUM_OPS - 1)) && r_phase;
    end

    // accumulate a partial product
    always_comb begin
        term    = r_p_hi ? (AW'(r_prod) <<< 34) : AW'(r_prod);
        acc_sum = r_p_neg ? r_acc - term : r_acc + term;
    end

    // sign fold checks and divider step
    always_comb begin
        dma    = $signed(r_d) - r_fa;
        dmab   = dma - r_fb;
        reject = r_zero || (r_d < AW'(i_eps)) || r_fa[AW-1] || dma[AW-1]
              || r_fb[AW-1] || dmab[AW-1] || r_ft[AW-1] || (r_ft == '0);
        x_val  = DW'($unsigned(r_ft)) << 16;
        d_lim  = DW'(r_d) << 31;
        sat    = x_val >= d_lim;
        ge     = r_rem >= r_dsh;
    end

    // candidate against running minimum
    always_comb begin
        cand     = r_ent.counted && (r_t != '0) && (!r_found || (r_t < r_best));
        out_free = !r_out_vld || i_m_tready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chtb_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_entry.counted ? chtb_pkg::ST_MUL : chtb_pkg::ST_UPD;
                end
            end
            chtb_pkg::ST_MUL: begin
                if (last_step) n_state = chtb_pkg::ST_DRAIN;
            end
            chtb_pkg::ST_DRAIN: n_state = chtb_pkg::ST_CHK1;
            chtb_pkg::ST_CHK1:  n_state = chtb_pkg::ST_CHK2;
            chtb_pkg::ST_CHK2: begin
                n_state = (reject || sat) ? chtb_pkg::ST_UPD : chtb_pkg::ST_DIV;
            end
            chtb_pkg::ST_DIV: begin
                if (r_bit == 5'd0) n_state = chtb_pkg::ST_UPD;
            end
            chtb_pkg::ST_UPD: begin
                if (!r_ent.last || out_free) n_state = chtb_pkg::ST_IDLE;
            end
            default: n_state = chtb_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        upd_acc  = 1'b0;
        case (r_state)
            chtb_pkg::ST_IDLE: o_pop = i_valid;
            chtb_pkg::ST_UPD: begin
                upd_acc  = !r_ent.last || out_free;
                out_load = r_ent.last && out_free;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= chtb_pkg::ST_IDLE;
            r_op      <= '0;
            r_phase   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_best    <= chtb_pkg::DIST_MAX;
            r_bidx    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= r_state == chtb_pkg::ST_MUL;
            if (r_state == chtb_pkg::ST_MUL) begin
                r_phase <= !r_phase;
                if (r_phase) r_op <= last_step ? 5'd0 : r_op + 5'd1;
            end
            if (upd_acc) begin
                if (r_ent.last) begin
                    r_found <= 1'b0;
                    r_best  <= chtb_pkg::DIST_MAX;
                    r_bidx  <= '0;
                end else if (cand) begin
                    r_found <= 1'b1;
                    r_best  <= r_t;
                    r_bidx  <= r_ent.index;
                end
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
            r_acc <= '0;
            r_t   <= '0;
        end
        // product stage
        r_prod   <= prod;
        r_p_hi   <= r_phase;
        r_p_neg  <= op.neg;
        r_p_done <= op.done && r_phase;
        r_p_dest <= op.dest;
        // accumulate stage
        if (r_p_vld) begin
            if (r_p_done) begin
                r_acc <= '0;
                case (r_p_dest)
                    chtb_pkg::DST_DET: r_det <= acc_sum;
                    chtb_pkg::DST_NA:  r_na  <= acc_sum;
                    chtb_pkg::DST_NB:  r_nb  <= acc_sum;
                    chtb_pkg::DST_NT:  r_nt  <= acc_sum;
                    default:           r_uvw[r_p_dest] <= acc_sum[BW-1:0];
                endcase
            end else begin
                r_acc <= acc_sum;
            end
        end
        // fold the determinant sign into the numerators
        if (r_state == chtb_pkg::ST_CHK1) begin
            r_zero <= r_det == '0;
            r_d    <= r_det[AW-1] ? $unsigned(-r_det) : $unsigned(r_det);
            r_fa   <= r_det[AW-1] ? -r_na : r_na;
            r_fb   <= r_det[AW-1] ? -r_nb : r_nb;
            r_ft   <= r_det[AW-1] ? -r_nt : r_nt;
        end
        if (r_state == chtb_pkg::ST_CHK2) begin
            if (reject) begin
                r_t <= '0;
            end else if (sat) begin
                r_t <= chtb_pkg::DIST_MAX;
            end
            r_rem <= x_val;
            r_dsh <= DW'(r_d) << 30;
            r_bit <= 5'd30;
            r_q   <= '0;
        end
        // one quotient bit per cycle
        if (r_state == chtb_pkg::ST_DIV) begin
            r_rem <= ge ? r_rem - r_dsh : r_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[chtb_pkg::DIST_W-2:0], ge};
            r_bit <= r_bit - 5'd1;
            if (r_bit == 5'd0) r_t <= {r_q[chtb_pkg::DIST_W-2:0], ge};
        end
        // result word
        if (out_load) begin
            r_out_hit  <= r_found || cand;
            r_out_idx  <= cand ? r_ent.index : (r_found ? r_bidx : '0);
            r_out_dist <= cand ? r_t : (r_found ? r_best : '0);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tdata  = {7'd0, r_out_dist, r_out_idx};

endmodule

>>> hdl/chtb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtb_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "closest_hit_triangle_batch_assert.svh"

module chtb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [chtb_pkg::OUT_W-1:0]      o_m_tdata,
    input logic                            o_m_tuser
);

    // a stalled result word holds
    `CHTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result word changed while stalled")

    // a miss reports zero index and distance
    `CHTB_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == '0, "miss with nonzero data")

    // a hit always has a distance of at least one
    `CHTB_ASSERT_IMPL(a_hit_dist, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata[40:10] != '0, "hit with zero distance")

    // no result word right after reset
    `CHTB_ASSERT_NEXT_NR(a_rst_idle, i_clk, !i_rst_n, !o_m_tvalid, "result valid after reset")

endmodule

bind closest_hit_triangle_batch chtb_checker u_chk (.*);
